// ===== rtl/core/trle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types, constants and helpers for the Targa run-coded pixel decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int PALETTE_DEPTH = 256;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PIXEL_KIND     = 3'd0,
    REG_SOURCE_BYTES   = 3'd1,
    REG_RUN_CODED      = 3'd2,
    REG_PIXEL_TOTAL    = 3'd3,
    REG_PALETTE_IS_555 = 3'd4
  } trle_reg_t;

  // pixel kinds (kind 3 decodes as direct)
  localparam logic [1:0] KIND_DIRECT  = 2'd0;
  localparam logic [1:0] KIND_RGB555  = 2'd1;
  localparam logic [1:0] KIND_PALETTE = 2'd2;

  // stream actions
  localparam logic ACT_STREAM  = 1'b0;
  localparam logic ACT_PALETTE = 1'b1;

  localparam logic [7:0]  HDR_COUNT_MASK = 8'h7F;
  localparam logic [15:0] MASK_B555      = 16'h001F;
  localparam logic [15:0] MASK_G555      = 16'h03E0;
  localparam logic [15:0] MASK_R555      = 16'h7C00;

  typedef struct packed {
    logic [1:0] pixel_kind;
    logic [2:0] source_bytes;
    logic       run_coded;
  } trle_cfg_t;

  // one decoded pixel leaving the parser
  typedef struct packed {
    logic        valid;
    logic        from_palette;
    logic [31:0] value;       // pixel, or palette index when from_palette
    logic [7:0]  count;
    logic        done;
    logic        over;
  } trle_res_t;

  function automatic logic [31:0] expand_555(input logic [15:0] v);
    logic [15:0] b;
    logic [15:0] g;
    logic [15:0] r;
    b = v & MASK_B555;
    g = (v & MASK_G555) >> 5;
    r = (v & MASK_R555) >> 10;
    return {8'h00, r[4:0], 3'b000, g[4:0], 3'b000, b[4:0], 3'b000};
  endfunction

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Targa pixel stream decoder: run-coded or plain bytes in, one request per
// decoded pixel out with its repeat count, palette held in a RAM.
// ----------------------------------------------------------------------------
// Throughput: one input request per cycle while the output is not back-pressured; no stall for runs.
// Output path: a pixel whose last byte is taken passes the palette RAM read
//   stage (stage 1), then the output register, before it appears on m_tdata.
// Reset (rst, synchronous): registers to their defaults, pixel count to 1,
//   parser expecting a header, pipeline empty. Palette RAM is not cleared.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
  import trle_pkg::*;
#(
  parameter int PAL_DEPTH = PALETTE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,

  // configuration write port
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,

  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // stream_byte[7:0], palette_slot[15:8], palette_value[47:16]
  input  logic        s_tuser,   // action: 0 stream byte, 1 palette write

  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pixel_value[31:0], repeat_count[39:32], overrun[40], zero
  output logic        m_tlast    // image_done
);

  localparam int PAL_AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  trle_cfg_t cfg;
  logic      palette_is_555;
  logic      restart;

  assign restart = cfg_wen && (trle_reg_t'(cfg_index) == REG_PIXEL_TOTAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_kind   <= KIND_DIRECT;
      cfg.source_bytes <= 3'd3;
      cfg.run_coded    <= 1'b1;
      palette_is_555   <= 1'b0;
    end else if (cfg_wen) begin
      case (trle_reg_t'(cfg_index))
        REG_PIXEL_KIND:     cfg.pixel_kind   <= cfg_data[1:0];
        REG_SOURCE_BYTES:   cfg.source_bytes <= cfg_data[2:0];
        REG_RUN_CODED:      cfg.run_coded    <= cfg_data[0];
        REG_PALETTE_IS_555: palette_is_555   <= cfg_data[0];
        default: ;          // pixel total handled by the parser restart
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input fields and handshake
  // --------------------------------------------------------------------------
  logic        in_acc;
  logic [7:0]  stream_byte;
  logic [7:0]  palette_slot;
  logic [31:0] palette_value;

  assign stream_byte   = s_tdata[7:0];
  assign palette_slot  = s_tdata[15:8];
  assign palette_value = s_tdata[47:16];
  assign in_acc        = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // parser
  // --------------------------------------------------------------------------
  trle_res_t res;

  trle_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .restart       (restart),
    .restart_total (cfg_data),
    .step          (in_acc && (s_tuser == ACT_STREAM)),
    .stream_byte   (stream_byte),
    .res           (res)
  );

  // --------------------------------------------------------------------------
  // palette RAM: writes land at the accept edge, so a later index read
  // always sees them; a stream item and a palette write never share a cycle.
  // --------------------------------------------------------------------------
  logic              pal_wen;
  logic [31:0]       slot_ext;
  logic [31:0]       pal_wdata;
  logic [31:0]       pal_rdata;
  logic              idx_in_range;

  assign slot_ext     = {24'd0, palette_slot};
  assign pal_wen      = in_acc && (s_tuser == ACT_PALETTE) && (slot_ext < 32'(PAL_DEPTH));
  assign pal_wdata    = palette_is_555 ? expand_555(palette_value[15:0]) : palette_value;
  assign idx_in_range = (res.value < 32'(PAL_DEPTH));

  trle_ram #(
    .WIDTH  (32),
    .DEPTH  (PAL_DEPTH),
    .ADDR_W (PAL_AW)
  ) u_palette (
    .clk   (clk),
    .wen   (pal_wen),
    .waddr (slot_ext[PAL_AW-1:0]),
    .wdata (pal_wdata),
    .ren   (in_acc),              // read data holds while stage 1 is stalled
    .raddr (res.value[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: waits on the RAM read; stage 2: output register
  // --------------------------------------------------------------------------
  trle_res_t   s1;
  logic        s1_in_range;
  logic        s1_valid;
  logic        s1_move;
  logic        s2_free;
  logic [31:0] s1_pixel;

  logic [31:0] out_pixel;
  logic [7:0]  out_count;
  logic        out_over;

  assign s2_free  = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && s2_free;
  assign s_tready = !s1_valid || s2_free;

  always_comb begin
    if (!s1.from_palette) begin
      s1_pixel = s1.value;
    end else if (s1_in_range) begin
      s1_pixel = pal_rdata;
    end else begin
      s1_pixel = 32'd0;                 // index past the palette reads zero
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= res.valid;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1          <= res;
      s1_in_range <= idx_in_range;
    end
    if (s1_move) begin
      out_pixel <= s1_pixel;
      out_count <= s1.count;
      out_over  <= s1.over;
      m_tlast   <= s1.done;
    end
  end

  assign m_tdata = {7'd0, out_over, out_count, out_pixel};

endmodule

// ===== rtl/core/trle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trle_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wen,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              ren,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/trle_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_parse
// Packet header / byte gather / pixel count tracking for the stream bytes.
// ----------------------------------------------------------------------------
module trle_parse
  import trle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  trle_cfg_t   cfg,
  input  logic        restart,        // pixel total written
  input  logic [31:0] restart_total,
  input  logic        step,           // stream byte accepted
  input  logic [7:0]  stream_byte,
  output trle_res_t   res
);

  logic [7:0]  packet_left;
  logic        packet_is_run;
  logic [1:0]  byte_phase;
  logic [31:0] pixel_gather;
  logic [31:0] pixels_left;

  logic [2:0]  need;
  logic        header;
  logic        live;
  logic        complete;
  logic [31:0] gather_or;
  logic        is_run_pkt;
  logic        clip;
  logic [7:0]  count;
  logic [31:0] left_after;
  logic [7:0]  pkt_after;
  logic        done;

  always_comb begin
    if (cfg.pixel_kind == KIND_RGB555) begin
      need = 3'd2;
    end else if (cfg.source_bytes == 3'd0) begin
      need = 3'd1;
    end else if (cfg.source_bytes > 3'd4) begin
      need = 3'd4;
    end else begin
      need = cfg.source_bytes;
    end

    live       = (pixels_left != 32'd0);
    header     = cfg.run_coded && (packet_left == 8'd0);
    gather_or  = pixel_gather | (32'(stream_byte) << {byte_phase, 3'b000});
    complete   = !header && (({1'b0, byte_phase} + 3'd1) >= need);

    is_run_pkt = cfg.run_coded && packet_is_run;
    clip       = is_run_pkt && ({24'd0, packet_left} > pixels_left);
    if (!is_run_pkt) begin
      count = 8'd1;
    end else if (clip) begin
      count = pixels_left[7:0];
    end else begin
      count = packet_left;
    end
    left_after = pixels_left - {24'd0, count};

    if (is_run_pkt) begin
      pkt_after = 8'd0;
    end else if (cfg.run_coded && (packet_left != 8'd0)) begin
      pkt_after = packet_left - 8'd1;
    end else begin
      pkt_after = packet_left;
    end
    done = (left_after == 32'd0);

    res.valid        = step && live && complete;
    res.from_palette = (cfg.pixel_kind == KIND_PALETTE);
    res.value        = (cfg.pixel_kind == KIND_RGB555) ? expand_555(gather_or[15:0])
                                                       : gather_or;
    res.count        = count;
    res.done         = done;
    res.over         = clip || (done && (pkt_after != 8'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_left   <= 8'd0;
      packet_is_run <= 1'b0;
      byte_phase    <= 2'd0;
      pixel_gather  <= 32'd0;
      pixels_left   <= 32'd1;
    end else if (restart) begin
      packet_left   <= 8'd0;
      packet_is_run <= 1'b0;
      byte_phase    <= 2'd0;
      pixel_gather  <= 32'd0;
      pixels_left   <= restart_total;
    end else if (step && live) begin
      if (header) begin
        packet_left   <= (stream_byte & HDR_COUNT_MASK) + 8'd1;
        packet_is_run <= stream_byte[7];
        byte_phase    <= 2'd0;
        pixel_gather  <= 32'd0;
      end else if (!complete) begin
        pixel_gather <= gather_or;
        byte_phase   <= byte_phase + 2'd1;
      end else begin
        pixel_gather <= 32'd0;
        byte_phase   <= 2'd0;
        pixels_left  <= left_after;
        packet_left  <= done ? 8'd0 : pkt_after;
      end
    end
  end

endmodule

// ===== bench/tga_rle_pixel_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Self-checking bench for the Targa pixel decoder. A directed table covers
// defaults, extremes and corner cases. Randomized phases follow, each with a
// new register setup and a mix of headers, pixel bytes and palette loads.
// Every decoded pixel is checked against the in-bench model or a hand-typed result.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  import trle_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;  // decodes as direct
  localparam int ITEM_BUDGET = 550;
  localparam int STALL_LIMIT = 2000;          // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 8;           // pipeline is two stages deep

  typedef struct {
    logic        act;
    logic [7:0]  sbyte;
    logic [7:0]  slot;
    logic [31:0] pval;
  } stream_item_t;

  typedef struct {
    logic [31:0] value;
    logic [7:0]  count;
    logic        done;
    logic        over;
  } pixel_rec_t;

  typedef enum {ROW_BYTE, ROW_PAL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    trle_reg_t   reg_idx;
    logic [31:0] data;      // stream byte, palette value or register value
    logic [7:0]  slot;
    bit          has_want;  // hand-typed result instead of the model
    pixel_rec_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // stream_byte[7:0], palette_slot[15:8], palette_value[47:16]
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // pixel_value[31:0], repeat_count[39:32], overrun[40]
  logic        m_tlast;        // image_done

  tga_rle_pixel_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model state: register shadow, parser state and palette contents.
  // --------------------------------------------------------------------------
  logic [1:0]  cfg_kind;
  logic [2:0]  cfg_src;
  logic        cfg_rle;
  logic [31:0] cfg_total;
  logic        cfg_pal555;

  logic [7:0]  pkt_left;    // 0 means the next byte is a packet header when run coded
  logic        pkt_run;
  logic [1:0]  phase;       // bytes of the current pixel gathered so far
  logic [31:0] gather;
  logic [31:0] px_left;
  logic [31:0] pal_mem [PALETTE_DEPTH];
  bit          pal_loaded [PALETTE_DEPTH];
  int          loaded_slots [$];

  pixel_rec_t  pending_pixels [$];  // decoded pixels not yet seen on m_*
  dir_row_t    directed_rows [$];
  int          errors = 0;
  int          effective = 0;       // requests that the decoder acted on
  bit          burst_mode = 1'b0;   // no idling on either side while set
  int          stall_cycles = 0;
  pixel_rec_t  seen_want;

  function automatic logic [31:0] bgr_from_555(input logic [15:0] v);
    return {8'h00, v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
  endfunction

  // Bytes per pixel under the current setup; rgb555 always takes two.
  function automatic int bytes_needed();
    if (cfg_kind == KIND_RGB555) return 2;
    if (cfg_src == 3'd0) return 1;
    if (cfg_src > 3'd4) return 4;
    return int'(cfg_src);
  endfunction

  function automatic void restart_image();
    pkt_left = '0;
    pkt_run  = 1'b0;
    phase    = '0;
    gather   = '0;
    px_left  = cfg_total;
  endfunction

  function automatic void model_reset();
    cfg_kind   = KIND_DIRECT;
    cfg_src    = 3'd3;
    cfg_rle    = 1'b1;
    cfg_total  = 32'd1;
    cfg_pal555 = 1'b0;
    foreach (pal_loaded[i]) begin
      pal_loaded[i] = 1'b0;
      pal_mem[i]    = '0;
    end
    restart_image();
  endfunction

  function automatic void model_write_reg(input trle_reg_t idx, input logic [31:0] v);
    case (idx)
      REG_PIXEL_KIND:     cfg_kind = v[1:0];
      REG_SOURCE_BYTES:   cfg_src = v[2:0];
      REG_RUN_CODED:      cfg_rle = v[0];
      REG_PIXEL_TOTAL: begin
        cfg_total = v;
        restart_image();
      end
      REG_PALETTE_IS_555: cfg_pal555 = v[0];
      default: ;
    endcase
  endfunction

  // Advance the decoder model by one request; returns 1 when a pixel comes out.
  function automatic bit decode_request(input stream_item_t it, output pixel_rec_t px);
    int          need;
    logic [31:0] value;
    logic [31:0] cnt;
    logic        over;
    px = '{default: '0};
    if (it.act == ACT_PALETTE) begin
      pal_mem[it.slot] = cfg_pal555 ? bgr_from_555(it.pval[15:0]) : it.pval;
      if (!pal_loaded[it.slot]) begin
        pal_loaded[it.slot] = 1'b1;
        loaded_slots.push_back(int'(it.slot));
      end
      return 1'b0;
    end
    if (px_left == 0) return 1'b0;  // image complete, byte dropped
    if (cfg_rle && pkt_left == 0) begin
      pkt_left = {1'b0, it.sbyte[6:0]} + 8'd1;
      pkt_run  = it.sbyte[7];
      phase    = '0;
      gather   = '0;
      return 1'b0;
    end
    need = bytes_needed();
    gather |= 32'(it.sbyte) << (8 * phase);
    if (int'(phase) + 1 < need) begin
      phase = phase + 2'd1;
      return 1'b0;
    end
    if (cfg_kind == KIND_RGB555)
      value = bgr_from_555(gather[15:0]);
    else if (cfg_kind == KIND_PALETTE)
      value = (gather < PALETTE_DEPTH) ? pal_mem[gather[7:0]] : 32'd0;
    else
      value = gather;
    phase  = '0;
    gather = '0;
    over   = 1'b0;
    if (cfg_rle && pkt_run) begin
      // run packet: one request for the whole run, clipped at image end
      cnt = 32'(pkt_left);
      pkt_left = '0;
      if (cnt > px_left) begin
        cnt  = px_left;
        over = 1'b1;
      end
    end else begin
      cnt = 32'd1;
      if (cfg_rle && pkt_left > 0) pkt_left = pkt_left - 8'd1;
    end
    px_left = px_left - cnt;
    if (px_left == 0) begin
      // raw packet still holding pixels past the end of the image
      if (pkt_left > 0) over = 1'b1;
      pkt_left = '0;
    end
    px.value = value;
    px.count = cnt[7:0];
    px.done  = (px_left == 0);
    px.over  = over;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  function automatic void add_row(input row_kind_t k, input trle_reg_t idx,
                                  input logic [31:0] d, input logic [7:0] s);
    dir_row_t r;
    r = '{kind: k, reg_idx: idx, data: d, slot: s, has_want: 1'b0,
          want: '{default: '0}};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    add_row(ROW_BYTE, REG_PIXEL_KIND, 32'(b), 8'h00);
  endfunction

  function automatic void add_byte_want(input logic [7:0] b, input logic [31:0] v,
                                        input logic [7:0] c, input logic d, input logic o);
    add_byte(b);
    directed_rows[$].has_want = 1'b1;
    directed_rows[$].want = '{value: v, count: c, done: d, over: o};
  endfunction

  function automatic void add_cfg(input trle_reg_t idx, input logic [31:0] v);
    add_row(ROW_CFG, idx, v, 8'h00);
  endfunction

  function automatic void build_directed();
    // defaults: direct, 3 bytes, run coded, one pixel
    add_byte(8'h80);
    add_byte(8'h11);
    add_byte(8'h22);
    add_byte_want(8'h33, 32'h0033_2211, 8'd1, 1'b1, 1'b0);
    add_byte(8'h55);                              // after image end: dropped
    add_cfg(REG_PIXEL_TOTAL, 32'd0);
    add_byte(8'hAA);                              // zero-size image: dropped
    add_cfg(REG_SOURCE_BYTES, 32'd7);             // clamps to 4
    add_cfg(REG_PIXEL_TOTAL, 32'd130);
    add_byte(8'hFF);                              // longest run
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte_want(8'hFF, 32'hFFFF_FFFF, 8'd128, 1'b0, 1'b0);
    add_cfg(REG_SOURCE_BYTES, 32'd1);
    add_byte(8'h83);                              // run of 4, only 2 left
    add_byte_want(8'h00, 32'h0, 8'd2, 1'b1, 1'b1);
    add_cfg(REG_PIXEL_KIND, 32'(KIND_RGB555));
    add_cfg(REG_RUN_CODED, 32'd0);
    add_cfg(REG_PIXEL_TOTAL, 32'd3);
    add_byte(8'hFF);
    add_byte_want(8'h7F, 32'h00F8_F8F8, 8'd1, 1'b0, 1'b0);
    add_byte(8'h00);
    add_byte_want(8'h80, 32'h0, 8'd1, 1'b0, 1'b0);  // bit 15 dropped
    add_cfg(REG_PIXEL_KIND, 32'(KIND_UNUSED));
    add_cfg(REG_SOURCE_BYTES, 32'd0);             // acts as 1
    add_byte_want(8'h5A, 32'h0000_005A, 8'd1, 1'b1, 1'b0);
    add_cfg(REG_PALETTE_IS_555, 32'd1);
    add_cfg(REG_PIXEL_KIND, 32'(KIND_PALETTE));
    add_cfg(REG_SOURCE_BYTES, 32'd2);
    add_cfg(REG_PIXEL_TOTAL, 32'd2);
    add_row(ROW_PAL, REG_PIXEL_KIND, 32'hFFFF_FFFF, 8'hFF);
    add_byte(8'hFF);
    add_byte_want(8'h00, 32'h00F8_F8F8, 8'd1, 1'b0, 1'b0);
    add_byte(8'h00);
    add_byte_want(8'h01, 32'h0, 8'd1, 1'b1, 1'b0);  // index past the palette
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Drop valid, let all pending pixels drain, then let the pipeline settle.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input trle_reg_t idx, input logic [31:0] v);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    model_write_reg(idx, v);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Present one request, hold it until taken, then run it through the model.
  task automatic send_item(input stream_item_t it, input bit use_want,
                           input pixel_rec_t want, output bit acted);
    pixel_rec_t px;
    // idle cycles one at a time, about 22 in a hundred
    while (!burst_mode && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.pval, it.slot, it.sbyte};
    s_tuser  <= it.act;
    do @(posedge clk); while (!s_tready);
    acted = (it.act == ACT_PALETTE) || (px_left != 0);
    if (decode_request(it, px))
      pending_pixels.push_back(use_want ? want : px);
  endtask

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------
  function automatic logic [31:0] pick_total();
    int r;
    r = $urandom_range(99);
    if (r < 6)  return 32'd0;
    if (r < 12) return 32'hFFFE_0001;  // largest legal image
    if (r < 18) return 32'd1;
    return 32'($urandom_range(2, 48));
  endfunction

  function automatic logic [31:0] pick_palette_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic stream_item_t palette_item();
    stream_item_t it;
    it.act   = ACT_PALETTE;
    it.sbyte = 8'($urandom_range(255));
    it.slot  = 8'($urandom_range(1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    it.pval  = pick_palette_value();
    return it;
  endfunction

  // Never let a palette lookup land on an entry that was not loaded.
  function automatic logic [7:0] palette_safe(input logic [7:0] b);
    logic [31:0] idx;
    if (cfg_kind != KIND_PALETTE || px_left == 0) return b;
    if (cfg_rle && pkt_left == 0) return b;
    if (int'(phase) + 1 < bytes_needed()) return b;
    idx = gather | (32'(b) << (8 * phase));
    if (idx >= PALETTE_DEPTH || pal_loaded[idx[7:0]]) return b;
    if (phase == 0)
      return 8'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
    return 8'($urandom_range(1, 255));  // push the index past the palette
  endfunction

  function automatic stream_item_t next_item();
    stream_item_t it;
    int r;
    if ($urandom_range(99) < (cfg_kind == KIND_PALETTE ? 10 : 5)) return palette_item();
    it.act  = ACT_STREAM;
    it.slot = 8'($urandom_range(255));
    it.pval = $urandom;
    if (cfg_rle && pkt_left == 0 && px_left != 0) begin
      // packet header: mostly short packets, now and then a long one
      r = $urandom_range(99);
      it.sbyte[7]   = 1'($urandom_range(1));
      it.sbyte[6:0] = 7'((r < 70) ? $urandom_range(0, 7) :
                         (r < 90) ? $urandom_range(0, 31) : $urandom_range(96, 127));
    end else begin
      r = $urandom_range(99);
      it.sbyte = (r < 12) ? 8'h00 : (r < 24) ? 8'hFF : 8'($urandom_range(255));
      // keep most palette indexes inside the palette
      if (cfg_kind == KIND_PALETTE && phase != 0 && $urandom_range(9) < 7) it.sbyte = 8'h00;
      it.sbyte = palette_safe(it.sbyte);
    end
    return it;
  endfunction

  task automatic random_setup();
    wait_quiet();
    write_reg(REG_PIXEL_KIND, 32'($urandom_range(0, 3)));
    write_reg(REG_SOURCE_BYTES, 32'($urandom_range(0, 7)));
    write_reg(REG_RUN_CODED, 32'($urandom_range(0, 1)));
    write_reg(REG_PALETTE_IS_555, 32'($urandom_range(0, 1)));
    // sometimes keep the image going so a half-gathered pixel meets the new setup
    if ($urandom_range(99) < 85 || px_left == 0) write_reg(REG_PIXEL_TOTAL, pick_total());
  endtask

  task automatic run_phase();
    stream_item_t it;
    bit acted;
    int len;
    random_setup();
    if (cfg_kind == KIND_PALETTE) begin
      repeat ($urandom_range(2, 5)) begin
        it = palette_item();
        send_item(it, 1'b0, '{default: '0}, acted);
        effective++;
      end
    end
    len = $urandom_range(10, 50);
    for (int i = 0; i < len; i++) begin
      if (px_left == 0 && $urandom_range(3) == 0) break;
      burst_mode = (effective >= 200 && effective < 320);
      it = next_item();
      send_item(it, 1'b0, '{default: '0}, acted);
      if (acted) effective++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stream_item_t it;
    bit acted;
    model_reset();
    build_directed();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          wait_quiet();
          write_reg(directed_rows[i].reg_idx, directed_rows[i].data);
        end
        default: begin
          it.act   = (directed_rows[i].kind == ROW_PAL) ? ACT_PALETTE : ACT_STREAM;
          it.sbyte = directed_rows[i].data[7:0];
          it.slot  = directed_rows[i].slot;
          it.pval  = directed_rows[i].data;
          send_item(it, directed_rows[i].has_want, directed_rows[i].want, acted);
          if (acted) effective++;
        end
      endcase
    end

    while (effective < ITEM_BUDGET) run_phase();

    burst_mode = 1'b0;
    wait_quiet();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random backpressure and the pixel check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel request with none expected: value %h count %0d",
                 m_tdata[31:0], m_tdata[39:32]);
          errors++;
        end else begin
          seen_want = pending_pixels.pop_front();
          if (m_tdata[31:0] !== seen_want.value) begin
            $error("pixel_value expected %h actual %h", seen_want.value, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[39:32] !== seen_want.count) begin
            $error("repeat_count expected %0d actual %0d", seen_want.count, m_tdata[39:32]);
            errors++;
          end
          if (m_tlast !== seen_want.done) begin
            $error("image_done expected %0b actual %0b", seen_want.done, m_tlast);
            errors++;
          end
          if (m_tdata[40] !== seen_want.over) begin
            $error("overrun expected %0b actual %0b", seen_want.over, m_tdata[40]);
            errors++;
          end
        end
      end
      m_tready <= burst_mode || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: any long stretch with no handshake means the decoder hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
